[rtl/ase_pkg.sv]
// ----------------------------------------------------------------------------
// ase_pkg
// shared types, constants and elaboration-time math for the ambisonic encoder
// ----------------------------------------------------------------------------
package ase_pkg;

    localparam longint unsigned QONE = 64'd1 << 30;
    localparam longint unsigned PIH  = 64'd1686629713;
    localparam longint unsigned LN2Q = 64'd744261118;

    localparam int HIDX_W    = 6;   // harmonic counter, up to 2*31+1 harmonics
    localparam int PIDX_W    = 16;  // table point, up to 65536 points
    localparam int DIV_STEPS = 31;  // quotient bits of the fraction divider
    localparam int W_W       = 33;  // widening weight width

    typedef enum logic [1:0] {
        FRAC_DIV  = 2'd0,
        FRAC_ZERO = 2'd1,
        FRAC_ONE  = 2'd2
    } frac_mode_t;

    typedef struct packed {
        logic [HIDX_W-1:0] hidx;
        logic              last;
        logic              omni;
        logic              cosine;
        logic [PIDX_W-1:0] point;
        logic              far;
        frac_mode_t        mode;
        logic [30:0]       optim;
        logic [W_W-1:0]    weight;
    } side_t;

    typedef struct packed {
        logic [29:0] rem;
        logic        low;
        logic [29:0] divisor;
    } div_op_t;

    typedef struct packed {
        logic busy;
        logic last_issue;
    } seq_status_t;

    // shift-subtract division, elaboration use only
    function automatic longint unsigned udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], a[i]};
            if (rem >= b) begin
                rem  = rem - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned sin_quad(input longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned s;
        x  = (r * PIH) >> 30;
        x2 = (x * x) >> 30;
        s  = QONE - x2 / 110;
        s  = QONE - ((x2 * s) >> 30) / 72;
        s  = QONE - ((x2 * s) >> 30) / 42;
        s  = QONE - ((x2 * s) >> 30) / 20;
        s  = QONE - ((x2 * s) >> 30) / 6;
        s  = (x * s) >> 30;
        return (s > QONE) ? QONE : s;
    endfunction

    function automatic logic [31:0] sin_turn(input logic [31:0] t);
        longint unsigned r;
        longint unsigned v;
        r = 64'(t[29:0]);
        if (t[30]) begin
            r = QONE - r;
        end
        v = sin_quad(r);
        return t[31] ? (32'd0 - 32'(v)) : 32'(v);
    endfunction

    function automatic longint unsigned ln_q30(input longint unsigned m);
        longint unsigned k;
        longint unsigned y;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned term;
        longint unsigned sum;
        k   = 0;
        sum = 0;
        if (m == 0) begin
            return 0;
        end
        for (int b = 1; b < 32; b++) begin
            if ((m >> b) != 0) begin
                k = 64'(b);
            end
        end
        y    = (m << 30) >> k;
        z    = udiv64((y - QONE) << 30, y + QONE);
        z2   = (z * z) >> 30;
        term = z;
        for (int n = 1; n <= 21; n += 2) begin
            sum  = sum + udiv64(term, 64'(n));
            term = (term * z2) >> 30;
        end
        return k * LN2Q + 2 * sum;
    endfunction

endpackage

[rtl/ambisonic_source_encoder_with_widening_unit.sv]
// ----------------------------------------------------------------------------
// ambisonic_source_encoder_with_widening_unit
// two-dimensional ambisonic encoder with source widening, streaming top level
// ----------------------------------------------------------------------------
// Each accepted position (azimuth, radius) yields 2*ORDER+1 encoding gains, one
// per harmonic in order (omni, then sine and cosine of each order), the last
// one marked by m_tlast. Gains come out at one per cycle unless the output
// stalls; that rate is set by the harmonic sequencer, which issues one
// harmonic per cycle into the pipeline while the pipeline advances.
// The next position is taken in the cycle the last harmonic of the current one
// is issued, so positions follow each other with no gap. From a position
// transfer to its first gain the path runs through one issue stage, a 31-stage
// fraction divider and four gain stages. The whole pipeline holds while the
// result is stalled; an idle sequencer still takes a position. Reset clears
// the valid flags and the sequencer busy flag; data registers are not reset.
// ----------------------------------------------------------------------------
module ambisonic_source_encoder_with_widening_unit
    import ase_pkg::*;
#(
    parameter int ORDER         = 7,
    parameter int CIRCLE_POINTS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // azimuth [15:0], radius [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // harmonic_index [3:0], gain [19:4], zero [23:20]
    output logic        m_tlast     // last_gain
);

    // pipeline advance: output register empty or being taken
    logic        en;

    seq_status_t seq_status;
    logic        issue_valid;
    side_t       issue_side;
    div_op_t     issue_op;

    logic                 div_valid;
    side_t                div_side;
    logic [DIV_STEPS-1:0] div_quot;

    logic [3:0]  out_hidx;
    logic [15:0] out_gain;

    assign en = ~m_tvalid | m_tready;

    // position intake and harmonic issue
    ase_sequencer #(
        .ORDER         (ORDER),
        .CIRCLE_POINTS (CIRCLE_POINTS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .azimuth     (s_tdata[15:0]),
        .radius      (s_tdata[31:16]),
        .status      (seq_status),
        .issue_valid (issue_valid),
        .issue_side  (issue_side),
        .issue_op    (issue_op)
    );

    // widening fraction or far-field attenuation, one quotient bit per stage
    ase_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (issue_valid),
        .in_side   (issue_side),
        .in_op     (issue_op),
        .out_valid (div_valid),
        .out_side  (div_side),
        .out_quot  (div_quot)
    );

    // trig lookup, products and saturation, ends in the output register
    ase_gain_stage #(
        .CIRCLE_POINTS (CIRCLE_POINTS)
    ) u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid),
        .in_side   (div_side),
        .in_quot   (div_quot),
        .out_valid (m_tvalid),
        .out_hidx  (out_hidx),
        .out_gain  (out_gain),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'b0000, out_gain, out_hidx};

    // a position is taken while stalled only by an idle sequencer
    a_stall_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !en) |-> !seq_status.busy)
        else $error("position taken by a busy sequencer during a stall");

    // a busy sequencer takes the next position only on its final harmonic
    a_busy_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && seq_status.busy) |-> seq_status.last_issue)
        else $error("position taken before the last harmonic was issued");

    // the marked gain is the final harmonic
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[3:0] == 4'(2 * ORDER)))
        else $error("last flag on a harmonic other than the final one");

endmodule

[rtl/ase_sequencer.sv]
// ----------------------------------------------------------------------------
// ase_sequencer
// takes a position, issues one harmonic per cycle with divider operands if en
// ----------------------------------------------------------------------------
module ase_sequencer
    import ase_pkg::*;
#(
    parameter int ORDER         = 7,
    parameter int CIRCLE_POINTS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] azimuth,
    input  logic [15:0] radius,
    output seq_status_t status,
    output logic        issue_valid,
    output side_t       issue_side,
    output div_op_t     issue_op
);

    localparam int NH = 2 * ORDER + 1;
    localparam int JW = $clog2(NH);
    localparam int OW = $clog2(ORDER + 2);
    localparam int PW = $clog2(CIRCLE_POINTS);
    localparam int AW = PW + 16;
    localparam logic [AW:0] MODV = (AW+1)'(64'(CIRCLE_POINTS) << 16);

    typedef logic [31:0] ln_tab_t  [ORDER+2];
    typedef logic [30:0] opt_tab_t [ORDER+2];

    function automatic ln_tab_t build_ln();
        ln_tab_t t;
        for (int m = 0; m < ORDER + 2; m++) begin
            t[m] = 32'(ln_q30(64'(m)));
        end
        return t;
    endfunction

    function automatic opt_tab_t build_opt();
        opt_tab_t t;
        longint unsigned w;
        w    = QONE;
        t[0] = 31'(QONE);
        for (int i = 1; i <= ORDER; i++) begin
            w    = udiv64(w * 64'(ORDER - i + 1), 64'(ORDER + i));
            t[i] = 31'(w);
        end
        t[ORDER+1] = '0;
        return t;
    endfunction

    localparam ln_tab_t  LN_TAB  = build_ln();
    localparam opt_tab_t OPT_TAB = build_opt();
    localparam logic [31:0] LN_ORD = LN_TAB[ORDER+1];

    logic              busy_reg, busy_next;
    logic [JW-1:0]     j_reg;
    logic [OW-1:0]     ord_reg;
    logic              cos_reg;
    logic [AW-1:0]     acc_reg;
    logic [AW-1:0]     azcp_reg;
    logic              far_reg;
    logic [31:0]       wl_reg;
    logic [W_W-1:0]    weight_reg;
    logic [16:0]       rp_reg;

    logic              issue_valid_reg;
    side_t             issue_side_reg;
    div_op_t           issue_op_reg;

    logic              accept;
    logic              last;
    logic              last_issue;
    logic              omni;
    logic              far_in;
    logic [12:0]       w_in;
    logic [44:0]       wl_prod;
    logic [44:0]       wt_prod;
    logic [AW-1:0]     azcp_in;
    logic [AW:0]       acc_sum;
    logic [AW:0]       acc_step;
    logic [OW-1:0]     ord_up;
    logic signed [33:0] num;
    logic signed [32:0] den;
    frac_mode_t        mode;
    div_op_t           op;
    side_t             side;

    // intake products
    assign far_in  = (radius >= 16'd4096);
    assign w_in    = far_in ? 13'd4096 : radius[12:0];
    assign wl_prod = 45'(w_in) * 45'(LN_ORD);
    assign wt_prod = 45'(13'd4096 - w_in) * 45'(LN_ORD);
    assign azcp_in = AW'(64'(azimuth) * 64'(CIRCLE_POINTS));

    assign last       = (j_reg == JW'(NH - 1));
    assign last_issue = busy_reg & last;
    assign in_ready   = ~busy_reg | (en & last);
    assign accept     = in_valid & in_ready;
    assign omni       = (j_reg == '0);
    assign ord_up     = ord_reg + OW'(1);

    // phase of the next order, one conditional subtract keeps it in range
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, azcp_reg};
    assign acc_step = (acc_sum >= MODV) ? (acc_sum - MODV) : acc_sum;

    assign num = $signed({2'b00, wl_reg}) - $signed({2'b00, LN_TAB[ord_reg]});
    assign den = $signed({1'b0, LN_TAB[ord_up]}) - $signed({1'b0, LN_TAB[ord_reg]});

    always_comb begin
        if (far_reg) begin
            mode = FRAC_DIV;
        end else if (omni) begin
            mode = FRAC_ONE;
        end else if (num <= 34'sd0) begin
            mode = FRAC_ZERO;
        end else if (den <= 33'sd0) begin
            mode = FRAC_ONE;
        end else if (num >= 34'(den)) begin
            mode = FRAC_ONE;
        end else begin
            mode = FRAC_DIV;
        end
    end

    always_comb begin
        op.rem     = '0;
        op.low     = 1'b0;
        op.divisor = 30'd1;
        if (far_reg) begin
            op.rem     = 30'd4096;
            op.divisor = 30'(rp_reg);
        end else if (mode == FRAC_DIV) begin
            op.rem     = num[30:1];
            op.low     = num[0];
            op.divisor = den[29:0];
        end
    end

    always_comb begin
        side.hidx   = HIDX_W'(j_reg);
        side.last   = last;
        side.omni   = omni;
        side.cosine = cos_reg;
        side.point  = PIDX_W'(acc_reg[AW-1:16]);
        side.far    = far_reg;
        side.mode   = mode;
        side.optim  = omni ? 31'(QONE) : OPT_TAB[ord_reg];
        side.weight = weight_reg;
    end

    always_comb begin
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (en && last_issue) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            issue_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            if (en) begin
                issue_valid_reg <= busy_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            j_reg      <= '0;
            ord_reg    <= OW'(1);
            cos_reg    <= 1'b0;
            acc_reg    <= azcp_in;
            azcp_reg   <= azcp_in;
            far_reg    <= far_in;
            wl_reg     <= wl_prod[43:12];
            weight_reg <= W_W'(wt_prod[43:12]) + W_W'(QONE);
            rp_reg     <= 17'(radius) + 17'd4096;
        end else if (en && busy_reg) begin
            if (!last) begin
                j_reg <= j_reg + JW'(1);
            end
            if (!omni) begin
                if (!cos_reg) begin
                    cos_reg <= 1'b1;
                end else begin
                    cos_reg <= 1'b0;
                    acc_reg <= acc_step[AW-1:0];
                    if (!last) begin
                        ord_reg <= ord_up;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            issue_side_reg <= side;
            issue_op_reg   <= op;
        end
    end

    assign status.busy       = busy_reg;
    assign status.last_issue = last_issue;
    assign issue_valid       = issue_valid_reg;
    assign issue_side        = issue_side_reg;
    assign issue_op          = issue_op_reg;

endmodule

[rtl/ase_divider.sv]
// ----------------------------------------------------------------------------
// ase_divider
// pipelined restoring divider, one quotient bit per stage, sideband carried
// ----------------------------------------------------------------------------
module ase_divider
    import ase_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  side_t                in_side,
    input  div_op_t              in_op,
    output logic                 out_valid,
    output side_t                out_side,
    output logic [DIV_STEPS-1:0] out_quot
);

    logic [29:0]          rem_reg   [DIV_STEPS];
    logic [29:0]          dvs_reg   [DIV_STEPS];
    logic [DIV_STEPS-1:0] quot_reg  [DIV_STEPS];
    side_t                side_reg  [DIV_STEPS];
    logic                 valid_reg [DIV_STEPS];

    logic [29:0]          rem_src   [DIV_STEPS];
    logic [29:0]          dvs_src   [DIV_STEPS];
    logic [DIV_STEPS-1:0] quot_src  [DIV_STEPS];
    logic                 bit_src   [DIV_STEPS];
    logic [31:0]          diff      [DIV_STEPS];
    logic [29:0]          rem_next  [DIV_STEPS];
    logic [DIV_STEPS-1:0] quot_next [DIV_STEPS];

    always_comb begin
        rem_src[0]  = in_op.rem;
        dvs_src[0]  = in_op.divisor;
        quot_src[0] = '0;
        bit_src[0]  = in_op.low;
        for (int k = 1; k < DIV_STEPS; k++) begin
            rem_src[k]  = rem_reg[k-1];
            dvs_src[k]  = dvs_reg[k-1];
            quot_src[k] = quot_reg[k-1];
            bit_src[k]  = 1'b0;
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            diff[k] = {1'b0, rem_src[k], bit_src[k]} - {2'b00, dvs_src[k]};
            if (!diff[k][31]) begin
                rem_next[k] = diff[k][29:0];
            end else begin
                rem_next[k] = {rem_src[k][28:0], bit_src[k]};
            end
            quot_next[k] = {quot_src[k][DIV_STEPS-2:0], ~diff[k][31]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < DIV_STEPS; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int k = 1; k < DIV_STEPS; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 0; k < DIV_STEPS; k++) begin
                rem_reg[k]  <= rem_next[k];
                dvs_reg[k]  <= dvs_src[k];
                quot_reg[k] <= quot_next[k];
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];
    assign out_quot  = quot_reg[DIV_STEPS-1];

endmodule

[rtl/ase_gain_stage.sv]
// ----------------------------------------------------------------------------
// ase_gain_stage
// trig lookup, widening weight and the two gain products, then saturation
// ----------------------------------------------------------------------------
module ase_gain_stage
    import ase_pkg::*;
#(
    parameter int CIRCLE_POINTS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  side_t                in_side,
    input  logic [DIV_STEPS-1:0] in_quot,
    output logic                 out_valid,
    output logic [3:0]           out_hidx,
    output logic [15:0]          out_gain,
    output logic                 out_last
);

    localparam int PW = $clog2(CIRCLE_POINTS);

    typedef logic [63:0] rom_t [CIRCLE_POINTS];

    // {sine, cosine} of each table point, q30 two's complement
    function automatic rom_t build_rom();
        rom_t t;
        logic [31:0] ph;
        for (int p = 0; p < CIRCLE_POINTS; p++) begin
            ph   = 32'((64'(p) << 32) / CIRCLE_POINTS);
            t[p] = {sin_turn(ph), sin_turn(ph + 32'(QONE))};
        end
        return t;
    endfunction

    localparam rom_t TRIG_ROM = build_rom();

    // stage 1: table read, widening weight
    logic              v1_reg, v2_reg, v3_reg, vo_reg;
    logic [63:0]       rom1_reg;
    logic [W_W-1:0]    widen1_reg;
    logic [30:0]       optim1_reg;
    logic              omni1_reg, cos1_reg, last1_reg;
    logic [3:0]        hidx1_reg;
    // stage 2: trig times optimization weight
    logic [30:0]       m1_reg;
    logic              neg2_reg, last2_reg;
    logic [W_W-1:0]    widen2_reg;
    logic [3:0]        hidx2_reg;
    // stage 3: times widening weight
    logic [15:0]       m2_reg;
    logic              neg3_reg, last3_reg;
    logic [3:0]        hidx3_reg;
    // output register
    logic [15:0]       gain_reg;
    logic [3:0]        hidx_reg;
    logic              last_reg;

    logic [30:0]       frac;
    logic [63:0]       wprod;
    logic [W_W-1:0]    widen;
    logic [31:0]       trig;
    logic [30:0]       mag;
    logic [61:0]       m1_prod;
    logic [63:0]       m2_prod;
    logic [15:0]       gain_sat;

    always_comb begin
        case (in_side.mode)
            FRAC_ZERO: frac = '0;
            FRAC_ONE:  frac = 31'(QONE);
            default:   frac = in_quot;
        endcase
    end

    assign wprod = 64'(in_side.weight) * 64'(frac);
    assign widen = in_side.far ? W_W'(in_quot) : wprod[62:30];

    assign trig    = omni1_reg ? 32'(QONE) : (cos1_reg ? rom1_reg[31:0] : rom1_reg[63:32]);
    assign mag     = trig[31] ? 31'(32'd0 - trig) : trig[30:0];
    assign m1_prod = 62'(mag) * 62'(optim1_reg);

    assign m2_prod = 64'(m1_reg) * 64'(widen2_reg);

    always_comb begin
        if (neg3_reg) begin
            gain_sat = (m2_reg > 16'd32768) ? 16'h8000 : (16'd0 - m2_reg);
        end else begin
            gain_sat = (m2_reg > 16'd32767) ? 16'h7fff : m2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rom1_reg   <= TRIG_ROM[in_side.point[PW-1:0]];
            widen1_reg <= widen;
            optim1_reg <= in_side.optim;
            omni1_reg  <= in_side.omni;
            cos1_reg   <= in_side.cosine;
            last1_reg  <= in_side.last;
            hidx1_reg  <= in_side.hidx[3:0];

            m1_reg     <= m1_prod[60:30];
            neg2_reg   <= trig[31];
            widen2_reg <= widen1_reg;
            last2_reg  <= last1_reg;
            hidx2_reg  <= hidx1_reg;

            m2_reg     <= m2_prod[63:48];
            neg3_reg   <= neg2_reg;
            last3_reg  <= last2_reg;
            hidx3_reg  <= hidx2_reg;

            gain_reg   <= gain_sat;
            last_reg   <= last3_reg;
            hidx_reg   <= hidx3_reg;
        end
    end

    assign out_valid = vo_reg;
    assign out_hidx  = hidx_reg;
    assign out_gain  = gain_reg;
    assign out_last  = last_reg;

endmodule
